>>> rtl/nfc_pkg.sv
// Shared types, constants and the step microprogram of the cubic-roots Newton unit.
// Used by every module of the block but nfc_ram; depends on nothing else.
package nfc_pkg;

    localparam int FRAC_BITS = 32;
    localparam int INT_BITS  = 16;
    localparam int W         = INT_BITS + FRAC_BITS;
    localparam int TOL_W     = 33;
    localparam int ITER_W    = 8;
    localparam int ROOT_W    = 2;
    localparam int COLOUR_W  = 24;
    localparam int SLOTS     = 32;
    localparam int PC_W      = 6;

    typedef logic signed [W-1:0] word_t;

    localparam word_t FX_VMAX = {1'b0, {(W-1){1'b1}}};
    localparam word_t FX_VMIN = {1'b1, {(W-1){1'b0}}};
    localparam word_t FX_ONE  = {{(INT_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam word_t FX_HNEG = -(FX_ONE >>> 1);

    // Register map (byte address bit 3 selects the register).
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_MAX_ITER  = 1'b1;

    localparam logic [ROOT_W-1:0] ROOT_UP   = 2'd0;
    localparam logic [ROOT_W-1:0] ROOT_DN   = 2'd1;
    localparam logic [ROOT_W-1:0] ROOT_REAL = 2'd2;
    localparam logic [ROOT_W-1:0] ROOT_NONE = 2'd3;

    localparam logic [COLOUR_W-1:0] COLOUR_WHITE = 24'hFFFFFF;
    localparam logic [COLOUR_W-1:0] COLOUR_R     = 24'hFF0000;
    localparam logic [COLOUR_W-1:0] COLOUR_G     = 24'h00FF00;
    localparam logic [COLOUR_W-1:0] COLOUR_B     = 24'h0000FF;

    typedef struct packed {
        logic signed [W-1:0] start_re;
        logic signed [W-1:0] start_im;
    } in_t;

    typedef struct packed {
        logic signed [W-1:0]   final_re;
        logic signed [W-1:0]   final_im;
        logic [ITER_W-1:0]     iterations;
        logic [ROOT_W-1:0]     root_index;
        logic [COLOUR_W-1:0]   colour;
        logic                  singular;
    } out_t;

    typedef enum logic [3:0] {
        OP_MUL, OP_DIV, OP_CDIV, OP_ADD, OP_SUB, OP_SC3, OP_SC6, OP_NEG, OP_MOV,
        OP_CHK, OP_LOOP
    } op_t;

    typedef enum logic [4:0] {
        SL_X, SL_Y, SL_ONE, SL_XX, SL_YY, SL_XY, SL_T0, SL_T1, SL_F1, SL_F2,
        SL_A00, SL_A01, SL_A10, SL_DET, SL_I00, SL_I01, SL_I10, SL_I11,
        SL_S0, SL_S1, SL_NX, SL_NY, SL_DX, SL_DY, SL_RES
    } slot_t;

    typedef struct packed {
        op_t   op;
        slot_t dst;
        slot_t a;
        slot_t b;
    } uop_t;

    typedef struct packed {
        logic  start;
        op_t   op;
        word_t a;
        word_t b;
    } alu_req_t;

    typedef struct packed {
        logic  done;
        word_t result;
    } alu_rsp_t;

    localparam logic [PC_W-1:0] PC_LAST = 6'd43;

    // floor(sqrt(3) * 2^F), halved with rounding
    function automatic word_t half_sqrt3();
        logic [127:0] t;
        logic [127:0] s;
        logic [63:0]  v;
        logic [63:0]  c;
        t = 128'd3 << (2 * FRAC_BITS);
        v = '0;
        for (int b = FRAC_BITS; b >= 0; b--) begin
            c = v | (64'd1 << b);
            s = {64'd0, c} * {64'd0, c};
            if (s <= t) begin
                v = c;
            end
        end
        return W'((v + 64'd1) >> 1);
    endfunction

    localparam word_t FX_S3 = half_sqrt3();

    function automatic word_t box_cx(input logic [ROOT_W-1:0] k);
        return (k == ROOT_REAL) ? FX_ONE : FX_HNEG;
    endfunction

    function automatic word_t box_cy(input logic [ROOT_W-1:0] k);
        word_t r;
        unique case (k)
            ROOT_UP: r = FX_S3;
            ROOT_DN: r = -FX_S3;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [COLOUR_W-1:0] colour_base(input logic [ROOT_W-1:0] k);
        logic [COLOUR_W-1:0] r;
        unique case (k)
            ROOT_UP: r = COLOUR_R;
            ROOT_DN: r = COLOUR_G;
            default: r = COLOUR_B;
        endcase
        return r;
    endfunction

    // One Newton step as register-file micro-ops.
    function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            6'd0:  u = '{OP_MUL,  SL_XX,  SL_X,   SL_X};
            6'd1:  u = '{OP_MUL,  SL_YY,  SL_Y,   SL_Y};
            6'd2:  u = '{OP_MUL,  SL_XY,  SL_X,   SL_Y};
            6'd3:  u = '{OP_MUL,  SL_T0,  SL_YY,  SL_Y};
            6'd4:  u = '{OP_MUL,  SL_T1,  SL_XX,  SL_Y};
            6'd5:  u = '{OP_SC3,  SL_T1,  SL_T1,  SL_T1};
            6'd6:  u = '{OP_SUB,  SL_F1,  SL_T0,  SL_T1};
            6'd7:  u = '{OP_MUL,  SL_T0,  SL_XX,  SL_X};
            6'd8:  u = '{OP_MUL,  SL_T1,  SL_X,   SL_YY};
            6'd9:  u = '{OP_SC3,  SL_T1,  SL_T1,  SL_T1};
            6'd10: u = '{OP_SUB,  SL_T0,  SL_T0,  SL_T1};
            6'd11: u = '{OP_SUB,  SL_F2,  SL_T0,  SL_ONE};
            6'd12: u = '{OP_SC6,  SL_A00, SL_XY,  SL_XY};
            6'd13: u = '{OP_NEG,  SL_A00, SL_A00, SL_A00};
            6'd14: u = '{OP_SC3,  SL_T0,  SL_YY,  SL_YY};
            6'd15: u = '{OP_SC3,  SL_T1,  SL_XX,  SL_XX};
            6'd16: u = '{OP_SUB,  SL_A01, SL_T0,  SL_T1};
            6'd17: u = '{OP_SUB,  SL_A10, SL_T1,  SL_T0};
            6'd18: u = '{OP_MUL,  SL_T0,  SL_A00, SL_A00};
            6'd19: u = '{OP_MUL,  SL_T1,  SL_A01, SL_A10};
            6'd20: u = '{OP_SUB,  SL_DET, SL_T0,  SL_T1};
            6'd21: u = '{OP_CHK,  SL_DET, SL_DET, SL_DET};
            6'd22: u = '{OP_DIV,  SL_I00, SL_A00, SL_DET};
            6'd23: u = '{OP_NEG,  SL_T0,  SL_A01, SL_A01};
            6'd24: u = '{OP_DIV,  SL_I01, SL_T0,  SL_DET};
            6'd25: u = '{OP_NEG,  SL_T0,  SL_A10, SL_A10};
            6'd26: u = '{OP_DIV,  SL_I10, SL_T0,  SL_DET};
            6'd27: u = '{OP_DIV,  SL_I11, SL_A00, SL_DET};
            6'd28: u = '{OP_MUL,  SL_T0,  SL_I00, SL_F1};
            6'd29: u = '{OP_MUL,  SL_T1,  SL_I01, SL_F2};
            6'd30: u = '{OP_ADD,  SL_S0,  SL_T0,  SL_T1};
            6'd31: u = '{OP_MUL,  SL_T0,  SL_I10, SL_F1};
            6'd32: u = '{OP_MUL,  SL_T1,  SL_I11, SL_F2};
            6'd33: u = '{OP_ADD,  SL_S1,  SL_T0,  SL_T1};
            6'd34: u = '{OP_SUB,  SL_NX,  SL_X,   SL_S0};
            6'd35: u = '{OP_SUB,  SL_NY,  SL_Y,   SL_S1};
            6'd36: u = '{OP_SUB,  SL_DX,  SL_NX,  SL_X};
            6'd37: u = '{OP_SUB,  SL_DY,  SL_NY,  SL_Y};
            6'd38: u = '{OP_MUL,  SL_T0,  SL_DX,  SL_DX};
            6'd39: u = '{OP_MUL,  SL_T1,  SL_DY,  SL_DY};
            6'd40: u = '{OP_ADD,  SL_RES, SL_T0,  SL_T1};
            6'd41: u = '{OP_MOV,  SL_X,   SL_NX,  SL_NX};
            6'd42: u = '{OP_MOV,  SL_Y,   SL_NY,  SL_NY};
            default: u = '{OP_LOOP, SL_RES, SL_RES, SL_RES};
        endcase
        return u;
    endfunction

endpackage

>>> rtl/newton_fractal_cubic_roots_unit.sv
// Newton iteration for z^3 = 1 on one start point, Q16.32 with saturation.
// A start point runs up to max_iterations Newton steps (at least one) after a
// load of three register-file slots, then root classification and a colour
// division. Each step is 44 micro-ops on one shared arithmetic unit; its four
// divisions run a restoring loop and take most of a step's time, and the
// fifteen multiplies work on 16-bit chunks.
// in_stall is high from the request's acceptance until its result is loaded
// into the output register; a waiting result does not block the next request.
// Uses nfc_pkg, nfc_ram, nfc_alu and nfc_seq.
module newton_fractal_cubic_roots_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  nfc_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output nfc_pkg::out_t out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import nfc_pkg::*;

    localparam int AW = $clog2(SLOTS);

    logic [TOL_W-1:0]  tol_reg;
    logic [ITER_W-1:0] maxit_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr_a, ram_raddr_b;
    word_t             ram_wdata, ram_rdata_a, ram_rdata_b;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= TOL_W'(429497);
            maxit_reg <= ITER_W'(20);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[3] == REG_TOLERANCE)
                tol_reg <= pwdata[TOL_W-1:0];
            else
                maxit_reg <= pwdata[ITER_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_TOLERANCE) ? 64'(tol_reg) : 64'(maxit_reg);

    nfc_ram #(
        .WIDTH (W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    nfc_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    nfc_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .tolerance      (tol_reg),
        .max_iterations (maxit_reg),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr_a    (ram_raddr_a),
        .ram_raddr_b    (ram_raddr_b),
        .ram_rdata_a    (ram_rdata_a),
        .ram_rdata_b    (ram_rdata_b),
        .alu_req        (alu_req),
        .alu_rsp        (alu_rsp)
    );

endmodule

>>> rtl/nfc_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Stand-alone; no package needed.
module nfc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> rtl/nfc_alu.sv
// Shared fixed-point arithmetic unit: saturating add/sub/negate/scale/move with a
// registered result, 16-bit-chunk multiply and bit-serial restoring divide. Uses nfc_pkg.
module nfc_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  nfc_pkg::alu_req_t req,
    output nfc_pkg::alu_rsp_t rsp
);
    import nfc_pkg::*;

    localparam int PW  = 2 * W;
    localparam int CH  = (W + 15) / 16;
    localparam int MCW = $clog2(CH);
    localparam int PXW = CH * 16 + W;
    localparam int DW  = W + FRAC_BITS;
    localparam int DCW = $clog2(DW);
    localparam int XW  = W + 3;

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_MUL  = 5'b00010,
        A_MRND = 5'b00100,
        A_DIV  = 5'b01000,
        A_DRND = 5'b10000
    } aphase_t;

    aphase_t             phase_reg, phase_next;
    logic                done_reg, done_next;
    word_t               res_reg, res_next;
    logic                neg_reg, neg_next;
    logic                rnd_reg, rnd_next;
    logic [W-1:0]        ma_reg, ma_next;
    logic [CH*16-1:0]    mbx_reg, mbx_next;
    logic [PXW-1:0]      acc_reg, acc_next;
    logic [MCW-1:0]      mcnt_reg, mcnt_next;
    logic [DW-1:0]       num_reg, num_next;
    logic [DW-1:0]       quo_reg, quo_next;
    logic [W:0]          rem_reg, rem_next;
    logic [W-1:0]        md_reg, md_next;
    logic [DCW-1:0]      dcnt_reg, dcnt_next;

    logic [W-1:0]        mag_a, mag_b;
    logic [W+15:0]       pp;
    logic [PW-1:0]       mrq;
    logic [W:0]          rsh;
    logic [DW:0]         dq;
    logic signed [XW-1:0] ae, be, sv;

    function automatic logic [W-1:0] magn(input word_t v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic word_t clamp(input logic signed [XW-1:0] v);
        word_t r;
        if (v > $signed({4'b0000, {(W-1){1'b1}}}))
            r = FX_VMAX;
        else if (v < $signed({4'b1111, {(W-1){1'b0}}}))
            r = FX_VMIN;
        else
            r = W'(v);
        return r;
    endfunction

    function automatic word_t finish(input logic neg, input logic [PW-1:0] m);
        word_t r;
        if (m > PW'(FX_VMAX))
            r = neg ? FX_VMIN : FX_VMAX;
        else
            r = neg ? -W'(m) : W'(m);
        return r;
    endfunction

    always_comb
    begin
        mag_a = magn(req.a);
        mag_b = magn(req.b);
        ae    = XW'(req.a);
        be    = XW'(req.b);
        unique case (req.op)
            OP_ADD:  sv = ae + be;
            OP_SUB:  sv = ae - be;
            OP_NEG:  sv = -ae;
            OP_SC3:  sv = (ae <<< 1) + ae;
            OP_SC6:  sv = (ae <<< 2) + (ae <<< 1);
            default: sv = ae;
        endcase
        pp  = (W + 16)'(ma_reg) * (W + 16)'(mbx_reg[16 * mcnt_reg +: 16]);
        mrq = (acc_reg[PW-1:0] + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        rsh = {rem_reg[W-1:0], num_reg[DW-1]};
        dq  = (DW + 1)'(quo_reg)
            + (DW + 1)'(rnd_reg && (rem_reg >= ((W + 1)'(md_reg) - rem_reg)));
    end

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        neg_next   = neg_reg;
        rnd_next   = rnd_reg;
        ma_next    = ma_reg;
        mbx_next   = mbx_reg;
        acc_next   = acc_reg;
        mcnt_next  = mcnt_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        md_next    = md_reg;
        dcnt_next  = dcnt_reg;
        unique case (phase_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    neg_next = req.a[W-1] ^ req.b[W-1];
                    unique case (req.op)
                        OP_MUL:
                        begin
                            ma_next    = mag_a;
                            mbx_next   = (CH * 16)'(mag_b);
                            acc_next   = '0;
                            mcnt_next  = '0;
                            phase_next = A_MUL;
                        end
                        OP_DIV, OP_CDIV:
                        begin
                            if (req.op == OP_DIV)
                                num_next = {mag_a, {FRAC_BITS{1'b0}}};
                            else
                                num_next = DW'(mag_a);
                            neg_next   = (req.op == OP_DIV) && (req.a[W-1] ^ req.b[W-1]);
                            rnd_next   = (req.op == OP_DIV);
                            md_next    = mag_b;
                            quo_next   = '0;
                            rem_next   = '0;
                            dcnt_next  = '0;
                            phase_next = A_DIV;
                        end
                        default:
                        begin
                            res_next  = clamp(sv);
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                acc_next  = acc_reg + (PXW'(pp) << (16 * mcnt_reg));
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == MCW'(CH - 1))
                    phase_next = A_MRND;
            end
            A_MRND:
            begin
                res_next   = finish(neg_reg, mrq);
                done_next  = 1'b1;
                phase_next = A_IDLE;
            end
            A_DIV:
            begin
                if (rsh >= (W + 1)'(md_reg))
                begin
                    rem_next = rsh - (W + 1)'(md_reg);
                    quo_next = {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh;
                    quo_next = {quo_reg[DW-2:0], 1'b0};
                end
                num_next  = {num_reg[DW-2:0], 1'b0};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(DW - 1))
                    phase_next = A_DRND;
            end
            A_DRND:
            begin
                res_next   = finish(neg_reg, PW'(dq));
                done_next  = 1'b1;
                phase_next = A_IDLE;
            end
            default: phase_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        neg_reg  <= neg_next;
        rnd_reg  <= rnd_next;
        ma_reg   <= ma_next;
        mbx_reg  <= mbx_next;
        acc_reg  <= acc_next;
        mcnt_reg <= mcnt_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        md_reg   <= md_next;
        dcnt_reg <= dcnt_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

>>> rtl/nfc_seq.sv
// Sequencer: runs the Newton step microprogram over the register file and the
// shared unit, classifies the final point and holds the result. Uses nfc_pkg.
module nfc_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  nfc_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output nfc_pkg::out_t                 out_data,
    input  logic [nfc_pkg::TOL_W-1:0]     tolerance,
    input  logic [nfc_pkg::ITER_W-1:0]    max_iterations,
    output logic                          ram_we,
    output logic [$clog2(nfc_pkg::SLOTS)-1:0] ram_waddr,
    output nfc_pkg::word_t                ram_wdata,
    output logic [$clog2(nfc_pkg::SLOTS)-1:0] ram_raddr_a,
    output logic [$clog2(nfc_pkg::SLOTS)-1:0] ram_raddr_b,
    input  nfc_pkg::word_t                ram_rdata_a,
    input  nfc_pkg::word_t                ram_rdata_b,
    output nfc_pkg::alu_req_t             alu_req,
    input  nfc_pkg::alu_rsp_t             alu_rsp
);
    import nfc_pkg::*;

    localparam int BW = ((W > TOL_W) ? W : TOL_W) + 2;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_LOAD  = 8'b00000010,
        S_FETCH = 8'b00000100,
        S_EXEC  = 8'b00001000,
        S_WAIT  = 8'b00010000,
        S_CLS   = 8'b00100000,
        S_COLR  = 8'b01000000,
        S_FIN   = 8'b10000000
    } state_t;

    state_t               state_reg, state_next;
    logic [PC_W-1:0]      pc_reg, pc_next;
    logic [ITER_W-1:0]    cnt_reg, cnt_next;
    logic [1:0]           ld_reg, ld_next;
    word_t                sre_reg, sre_next;
    word_t                sim_reg, sim_next;
    word_t                x_reg, x_next;
    word_t                y_reg, y_next;
    logic                 sing_reg, sing_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic [COLOUR_W-1:0]  colour_reg, colour_next;
    logic                 out_valid_reg, out_valid_next;
    out_t                 out_data_reg, out_data_next;

    uop_t                 uop;
    logic signed [BW-1:0] xs, ys, cxs, cys, es, ress;
    logic                 hit;

    always_comb
    begin
        uop  = uop_rom(pc_reg);
        xs   = BW'(x_reg);
        ys   = BW'(y_reg);
        cxs  = BW'(box_cx(root_reg));
        cys  = BW'(box_cy(root_reg));
        es   = $signed(BW'(tolerance));
        ress = BW'(ram_rdata_a);
        hit  = (ys < cys + es) && (ys > cys - es) && (xs < cxs + es) && (xs > cxs - es);
    end

    assign ram_raddr_a = uop.a;
    assign ram_raddr_b = uop.b;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        cnt_next       = cnt_reg;
        ld_next        = ld_reg;
        sre_next       = sre_reg;
        sim_next       = sim_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        sing_next      = sing_reg;
        root_next      = root_reg;
        colour_next    = colour_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = uop.dst;
        ram_wdata      = alu_rsp.result;
        alu_req        = '{start: 1'b0, op: uop.op, a: ram_rdata_a, b: ram_rdata_b};

        // drop a taken result
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sre_next   = in_data.start_re;
                    sim_next   = in_data.start_im;
                    cnt_next   = '0;
                    sing_next  = 1'b0;
                    ld_next    = '0;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                ram_we  = 1'b1;
                ld_next = ld_reg + 1'b1;
                priority if (ld_reg == 2'd0)
                begin
                    ram_waddr = SL_X;
                    ram_wdata = sre_reg;
                    x_next    = sre_reg;
                end
                else if (ld_reg == 2'd1)
                begin
                    ram_waddr = SL_Y;
                    ram_wdata = sim_reg;
                    y_next    = sim_reg;
                end
                else
                begin
                    ram_waddr  = SL_ONE;
                    ram_wdata  = FX_ONE;
                    pc_next    = '0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (uop.op == OP_CHK)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (ram_rdata_a == '0)
                    begin
                        sing_next   = 1'b1;
                        root_next   = ROOT_NONE;
                        colour_next = COLOUR_WHITE;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = S_FETCH;
                    end
                end
                else if (uop.op == OP_LOOP)
                begin
                    if (ress > es && cnt_reg < max_iterations)
                    begin
                        pc_next    = '0;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        root_next  = ROOT_UP;
                        state_next = S_CLS;
                    end
                end
                else
                begin
                    alu_req.start = 1'b1;
                    state_next    = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    ram_we = 1'b1;
                    if (uop.dst == SL_X)
                        x_next = alu_rsp.result;
                    if (uop.dst == SL_Y)
                        y_next = alu_rsp.result;
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_CLS:
            begin
                // test the three root boxes in order, one per cycle
                if (hit)
                begin
                    alu_req = '{start: 1'b1, op: OP_CDIV,
                                a: W'(colour_base(root_reg)), b: W'(cnt_reg)};
                    state_next = S_COLR;
                end
                else if (root_reg == ROOT_REAL)
                begin
                    root_next   = ROOT_NONE;
                    colour_next = COLOUR_WHITE;
                    state_next  = S_FIN;
                end
                else
                begin
                    root_next = root_reg + 1'b1;
                end
            end
            S_COLR:
            begin
                if (alu_rsp.done)
                begin
                    colour_next = alu_rsp.result[COLOUR_W-1:0] & colour_base(root_reg);
                    state_next  = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next = '{final_re: x_reg, final_im: y_reg,
                                      iterations: cnt_reg, root_index: root_reg,
                                      colour: colour_reg, singular: sing_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg       <= pc_next;
        cnt_reg      <= cnt_next;
        ld_reg       <= ld_next;
        sre_reg      <= sre_next;
        sim_reg      <= sim_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        sing_reg     <= sing_next;
        root_reg     <= root_next;
        colour_reg   <= colour_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/nfc_chk.sv
// Port-level checker for the cubic-roots Newton unit, bound to the top level.
// Uses nfc_pkg.
module nfc_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_stall,
    input nfc_pkg::out_t out_data
);
    import nfc_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("stalled result changed");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.iterations != '0)
        else $error("result with zero steps");

    a_singular: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.singular |-> out_data.root_index == ROOT_NONE)
        else $error("singular result matched a root");

    a_white: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.root_index == ROOT_NONE |-> out_data.colour == COLOUR_WHITE)
        else $error("unmatched point not white");

endmodule

bind newton_fractal_cubic_roots_unit nfc_chk u_nfc_chk (.*);
